### src/tkct_pkg.sv
// ---------------------------------------------------------------------------
// tkct_pkg: shared definitions for the two-key chord translator
// Command codes, sequencer states, default sizes and the key-pair match.
// ---------------------------------------------------------------------------
package tkct_pkg;

  localparam int unsigned TableEntriesDef  = 64;
  localparam int unsigned CodesPerEntryDef = 6;
  localparam int unsigned KeyCountDef      = 48;

  localparam int unsigned KeyW  = 6;
  localparam int unsigned CodeW = 32;
  localparam int unsigned TickW = 16;

  localparam logic [KeyW-1:0]  KeyNone      = 6'd63;
  localparam logic [TickW-1:0] TimeoutReset = 16'd50;

  typedef enum logic [1:0] {
    CMD_PRESS   = 2'd0,
    CMD_RELEASE = 2'd1,
    CMD_TICK    = 2'd2,
    CMD_WRITE   = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FETCH,
    ST_DRAIN
  } state_e;

  typedef enum logic {
    JOB_PAIR,
    JOB_FLUSH
  } job_e;

  // An entry whose second key is KeyNone is a single-key entry; otherwise
  // the two keys match in either order.
  function automatic logic key_match(input logic [2*KeyW-1:0] keys,
                                     input logic [KeyW-1:0]   k1,
                                     input logic [KeyW-1:0]   k2);
    logic [KeyW-1:0] a;
    logic [KeyW-1:0] b;
    logic            m;
    a = keys[KeyW-1:0];
    b = keys[2*KeyW-1:KeyW];
    if (b == KeyNone) begin
      m = (k2 == KeyNone) && (a == k1);
    end else begin
      m = ((a == k1) && (b == k2)) || ((a == k2) && (b == k1));
    end
    return m;
  endfunction

endpackage

### src/two_key_chord_translator_top.sv
// ---------------------------------------------------------------------------
// two_key_chord_translator_top: key events to keycode taps
// Holds one pending key, searches the chord table for key pairs and
// single-key entries, and streams the resulting taps.
// ---------------------------------------------------------------------------
//  channel | direction | handshake               | payload
//  in      | in        | in_valid_i / in_stall_o | command_i .. entry_code_i
//  out     | out       | out_valid_o/out_stall_i | tap_code_o, last_o
//  cfg     | in        | cfg_we_i                | cfg_wdata_i (timeout_ticks)
//
//  Table writes, plain presses and ticks that expire no key are handled in
//  idle. A lookup walks the key table one entry a cycle, then the code
//  memory one slot a cycle, then hands out one beat per cycle through the
//  output register while the output is not stalled.
//  Reset clears the valid bit of every table entry at once; no clearing pass.
//  The input stalls while an item is in work; a stalled output only delays
//  the drain, the final beat may still wait while the next item is taken.
// ---------------------------------------------------------------------------
module two_key_chord_translator_top #(
  parameter int unsigned TABLE_ENTRIES   = tkct_pkg::TableEntriesDef,
  parameter int unsigned CODES_PER_ENTRY = tkct_pkg::CodesPerEntryDef,
  parameter int unsigned KEY_COUNT       = tkct_pkg::KeyCountDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  // input items
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  command_i,
  input  logic [5:0]  key_i,
  input  logic [31:0] fallback_code_i,
  input  logic        mods_active_i,
  input  logic [5:0]  entry_index_i,
  input  logic [5:0]  entry_first_key_i,
  input  logic [5:0]  entry_second_key_i,
  input  logic [2:0]  entry_slot_i,
  input  logic [31:0] entry_code_i,
  // result items
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] tap_code_o,
  output logic        last_o
);

  localparam int unsigned KeyW      = tkct_pkg::KeyW;
  localparam int unsigned CodeW     = tkct_pkg::CodeW;
  localparam int unsigned TickW     = tkct_pkg::TickW;
  localparam int unsigned IdxW      = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int unsigned ScanW     = $clog2(TABLE_ENTRIES + 1);
  localparam int unsigned CodeDepth = TABLE_ENTRIES * CODES_PER_ENTRY;
  localparam int unsigned CAddrW    = (CodeDepth > 1) ? $clog2(CodeDepth) : 1;
  localparam int unsigned FSlotW    = $clog2(CODES_PER_ENTRY + 1);
  localparam int unsigned BufDepth  = CODES_PER_ENTRY + 2;
  localparam int unsigned BufIdxW   = $clog2(BufDepth);
  localparam int unsigned BufCntW   = $clog2(BufDepth + 1);

  localparam logic [KeyW-1:0]   KeyLimit   = KeyW'(KEY_COUNT);
  localparam logic [8:0]        TableLimit = 9'(TABLE_ENTRIES);
  localparam logic [3:0]        SlotLimit  = 4'(CODES_PER_ENTRY);
  localparam logic [ScanW-1:0]  ScanEnd    = ScanW'(TABLE_ENTRIES);
  localparam logic [FSlotW-1:0] FetchEnd   = FSlotW'(CODES_PER_ENTRY);
  localparam logic [FSlotW-1:0] LastSlot   = FSlotW'(CODES_PER_ENTRY - 1);
  localparam logic [CAddrW-1:0] CpeMul     = CAddrW'(CODES_PER_ENTRY);

  // control state
  tkct_pkg::state_e   state_q, state_d;
  tkct_pkg::job_e     job_q, job_d;
  logic [TickW-1:0]   timeout_q;
  logic               pend_vld_q, pend_vld_d;
  logic [KeyW-1:0]    pend_key_q, pend_key_d;
  logic [CodeW-1:0]   pend_fb_q, pend_fb_d;
  logic [TickW-1:0]   wait_q, wait_d;
  logic [TABLE_ENTRIES-1:0] valid_q;
  logic [ScanW-1:0]   scan_addr_q, scan_addr_d;
  logic               cmp_vld_q, cmp_vld_d;
  logic               sgl_hit_q, sgl_hit_d;
  logic [FSlotW-1:0]  fslot_q, fslot_d;
  logic               cf_vld_q, cf_vld_d;
  logic [BufCntW-1:0] buf_cnt_q, buf_cnt_d;
  logic [BufCntW-1:0] rd_q, rd_d;
  logic               out_vld_q, out_vld_d;

  // payload state
  logic [KeyW-1:0]    new_key_q, new_key_d;
  logic [CodeW-1:0]   new_fb_q, new_fb_d;
  logic [IdxW-1:0]    cmp_idx_q, cmp_idx_d;
  logic [IdxW-1:0]    sgl_idx_q, sgl_idx_d;
  logic [CAddrW-1:0]  fetch_base_q, fetch_base_d;
  logic [FSlotW-1:0]  cf_slot_q, cf_slot_d;
  logic [CodeW-1:0]   buf_q [BufDepth];
  logic [CodeW-1:0]   buf_d [BufDepth];
  logic [CodeW-1:0]   out_code_q, out_code_d;
  logic               out_last_q, out_last_d;

  // memories
  logic [2*KeyW-1:0]  keys_mem [TABLE_ENTRIES];
  logic [CodeW-1:0]   code_mem [CodeDepth];
  logic [2*KeyW-1:0]  keys_rd_q;
  logic [CodeW-1:0]   code_rd_q;

  // decode of the accepted item
  logic              in_acc;
  logic              key_ok, press_ok, rel_hit, tick_act, tick_exp, flush_req;
  logic              start_direct, start_pair, start_flush, make_new, start_scan;
  logic              tbl_we, code_we;
  logic [IdxW-1:0]   wr_idx;
  logic [CAddrW-1:0] code_waddr;

  assign in_acc    = in_valid_i && (state_q == tkct_pkg::ST_IDLE);
  assign key_ok    = key_i < KeyLimit;
  assign press_ok  = in_acc && (command_i == tkct_pkg::CMD_PRESS) && key_ok;
  assign rel_hit   = in_acc && (command_i == tkct_pkg::CMD_RELEASE) && pend_vld_q &&
                     (pend_key_q == key_i);
  assign tick_act  = in_acc && (command_i == tkct_pkg::CMD_TICK) && pend_vld_q;
  assign tick_exp  = tick_act && (wait_q <= TickW'(1));
  assign flush_req = rel_hit || tick_exp;

  assign start_direct = (press_ok || flush_req) && mods_active_i;
  assign start_pair   = press_ok && !mods_active_i && pend_vld_q && (pend_key_q != key_i);
  assign start_flush  = flush_req && !mods_active_i;
  assign make_new     = press_ok && !mods_active_i && !pend_vld_q;
  assign start_scan   = start_pair || start_flush;

  assign tbl_we     = in_acc && (command_i == tkct_pkg::CMD_WRITE) &&
                      ({3'b000, entry_index_i} < TableLimit);
  assign code_we    = tbl_we && ({1'b0, entry_slot_i} < SlotLimit);
  assign wr_idx     = IdxW'(entry_index_i);
  assign code_waddr = CAddrW'(CAddrW'(wr_idx) * CpeMul) + CAddrW'(entry_slot_i);

  // scan compare on the key word read last cycle
  logic            ent_ok, pair_now, sgl_now, sgl_found, pair_sel;
  logic            scan_done_all, scan_end, fetch_go, scan_re;
  logic [IdxW-1:0] sgl_idx, fetch_idx;

  assign ent_ok        = cmp_vld_q && valid_q[cmp_idx_q];
  assign pair_now      = ent_ok && tkct_pkg::key_match(keys_rd_q, pend_key_q, new_key_q);
  assign sgl_now       = ent_ok && tkct_pkg::key_match(keys_rd_q, pend_key_q,
                                                       tkct_pkg::KeyNone);
  assign sgl_found     = sgl_hit_q || sgl_now;
  assign sgl_idx       = sgl_hit_q ? sgl_idx_q : cmp_idx_q;
  assign pair_sel      = (job_q == tkct_pkg::JOB_PAIR) && pair_now;
  assign scan_done_all = (scan_addr_q == ScanEnd) && !cmp_vld_q;
  assign scan_end      = (state_q == tkct_pkg::ST_SCAN) &&
                         (pair_sel || ((job_q == tkct_pkg::JOB_FLUSH) && sgl_found) ||
                          scan_done_all);
  assign fetch_go      = scan_end && (pair_sel || sgl_found);
  assign fetch_idx     = pair_sel ? cmp_idx_q : sgl_idx;
  assign scan_re       = (state_q == tkct_pkg::ST_SCAN) && (scan_addr_q < ScanEnd);

  // code fetch, one slot a cycle
  logic              code_re, push, fetch_end;
  logic [CAddrW-1:0] code_raddr;

  assign code_re    = (state_q == tkct_pkg::ST_FETCH) && (fslot_q < FetchEnd);
  assign code_raddr = fetch_base_q + CAddrW'(fslot_q);
  assign push       = cf_vld_q && (code_rd_q != '0);
  assign fetch_end  = (state_q == tkct_pkg::ST_FETCH) && cf_vld_q &&
                      ((code_rd_q == '0) || (cf_slot_q == LastSlot));

  // drain
  logic out_free, drain_ld, drain_last;

  assign out_free   = !out_vld_q || !out_stall_i;
  assign drain_ld   = (state_q == tkct_pkg::ST_DRAIN) && out_free;
  assign drain_last = (rd_q + BufCntW'(1)) == buf_cnt_q;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      tkct_pkg::ST_IDLE: begin
        if (start_direct) begin
          state_d = tkct_pkg::ST_DRAIN;
        end else if (start_scan) begin
          state_d = tkct_pkg::ST_SCAN;
        end
      end
      tkct_pkg::ST_SCAN: begin
        if (scan_end) begin
          state_d = fetch_go ? tkct_pkg::ST_FETCH : tkct_pkg::ST_IDLE;
        end
      end
      tkct_pkg::ST_FETCH: begin
        if (fetch_end) begin
          state_d = (push || (buf_cnt_q != '0)) ? tkct_pkg::ST_DRAIN : tkct_pkg::ST_IDLE;
        end
      end
      tkct_pkg::ST_DRAIN: begin
        if (drain_ld && drain_last) begin
          state_d = tkct_pkg::ST_IDLE;
        end
      end
      default: state_d = tkct_pkg::ST_IDLE;
    endcase
  end

  // datapath updates
  always_comb begin
    job_d        = job_q;
    pend_vld_d   = pend_vld_q;
    pend_key_d   = pend_key_q;
    pend_fb_d    = pend_fb_q;
    wait_d       = wait_q;
    new_key_d    = new_key_q;
    new_fb_d     = new_fb_q;
    scan_addr_d  = scan_addr_q;
    cmp_vld_d    = 1'b0;
    cmp_idx_d    = cmp_idx_q;
    sgl_hit_d    = sgl_hit_q;
    sgl_idx_d    = sgl_idx_q;
    fetch_base_d = fetch_base_q;
    fslot_d      = fslot_q;
    cf_vld_d     = 1'b0;
    cf_slot_d    = cf_slot_q;
    buf_d        = buf_q;
    buf_cnt_d    = buf_cnt_q;
    rd_d         = rd_q;
    out_vld_d    = out_vld_q && out_stall_i;
    out_code_d   = out_code_q;
    out_last_d   = out_last_q;

    case (state_q)
      tkct_pkg::ST_IDLE: begin
        if (in_acc) begin
          rd_d        = '0;
          buf_cnt_d   = '0;
          scan_addr_d = '0;
          sgl_hit_d   = 1'b0;
        end
        if (tick_act && !tick_exp) begin
          wait_d = wait_q - TickW'(1);
        end
        if (tick_exp) begin
          wait_d = '0;
        end
        if (make_new) begin
          pend_vld_d = 1'b1;
          pend_key_d = key_i;
          pend_fb_d  = fallback_code_i;
          wait_d     = timeout_q;
        end
        if (start_direct) begin
          // flush the pending key by its fallback, then on a press tap the new fallback
          pend_vld_d = 1'b0;
          if (press_ok && pend_vld_q) begin
            buf_d[0]  = pend_fb_q;
            buf_d[1]  = fallback_code_i;
            buf_cnt_d = BufCntW'(2);
          end else if (press_ok) begin
            buf_d[0]  = fallback_code_i;
            buf_cnt_d = BufCntW'(1);
          end else begin
            buf_d[0]  = pend_fb_q;
            buf_cnt_d = BufCntW'(1);
          end
        end
        if (start_pair) begin
          job_d     = tkct_pkg::JOB_PAIR;
          new_key_d = key_i;
          new_fb_d  = fallback_code_i;
        end
        if (start_flush) begin
          job_d = tkct_pkg::JOB_FLUSH;
        end
      end

      tkct_pkg::ST_SCAN: begin
        if (scan_re) begin
          cmp_vld_d   = 1'b1;
          cmp_idx_d   = scan_addr_q[IdxW-1:0];
          scan_addr_d = scan_addr_q + ScanW'(1);
        end
        if (sgl_now && !sgl_hit_q) begin
          sgl_hit_d = 1'b1;
          sgl_idx_d = cmp_idx_q;
        end
        if (scan_end) begin
          cmp_vld_d = 1'b0;
          if ((job_q == tkct_pkg::JOB_PAIR) && !pair_now) begin
            // no chord: the old key flushes, the new key becomes pending
            pend_vld_d = 1'b1;
            pend_key_d = new_key_q;
            pend_fb_d  = new_fb_q;
            wait_d     = timeout_q;
          end else begin
            pend_vld_d = 1'b0;
          end
          fetch_base_d = CAddrW'(CAddrW'(fetch_idx) * CpeMul);
          fslot_d      = '0;
        end
      end

      tkct_pkg::ST_FETCH: begin
        if (code_re) begin
          cf_vld_d  = 1'b1;
          cf_slot_d = fslot_q;
          fslot_d   = fslot_q + FSlotW'(1);
        end
        if (push) begin
          buf_d[BufIdxW'(buf_cnt_q)] = code_rd_q;
          buf_cnt_d                  = buf_cnt_q + BufCntW'(1);
        end
        if (fetch_end) begin
          cf_vld_d = 1'b0;
        end
      end

      tkct_pkg::ST_DRAIN: begin
        if (drain_ld) begin
          out_vld_d  = 1'b1;
          out_code_d = buf_q[BufIdxW'(rd_q)];
          out_last_d = drain_last;
          rd_d       = rd_q + BufCntW'(1);
        end
      end

      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tkct_pkg::ST_IDLE;
      job_q       <= tkct_pkg::JOB_PAIR;
      timeout_q   <= tkct_pkg::TimeoutReset;
      pend_vld_q  <= 1'b0;
      pend_key_q  <= '0;
      pend_fb_q   <= '0;
      wait_q      <= '0;
      valid_q     <= '0;
      scan_addr_q <= '0;
      cmp_vld_q   <= 1'b0;
      sgl_hit_q   <= 1'b0;
      fslot_q     <= '0;
      cf_vld_q    <= 1'b0;
      buf_cnt_q   <= '0;
      rd_q        <= '0;
      out_vld_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      job_q       <= job_d;
      pend_vld_q  <= pend_vld_d;
      pend_key_q  <= pend_key_d;
      pend_fb_q   <= pend_fb_d;
      wait_q      <= wait_d;
      scan_addr_q <= scan_addr_d;
      cmp_vld_q   <= cmp_vld_d;
      sgl_hit_q   <= sgl_hit_d;
      fslot_q     <= fslot_d;
      cf_vld_q    <= cf_vld_d;
      buf_cnt_q   <= buf_cnt_d;
      rd_q        <= rd_d;
      out_vld_q   <= out_vld_d;
      if (cfg_we_i) begin
        timeout_q <= cfg_wdata_i;
      end
      if (tbl_we) begin
        valid_q[wr_idx] <= 1'b1;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    new_key_q    <= new_key_d;
    new_fb_q     <= new_fb_d;
    cmp_idx_q    <= cmp_idx_d;
    sgl_idx_q    <= sgl_idx_d;
    fetch_base_q <= fetch_base_d;
    cf_slot_q    <= cf_slot_d;
    buf_q        <= buf_d;
    out_code_q   <= out_code_d;
    out_last_q   <= out_last_d;
  end

  // key table: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (tbl_we) begin
      keys_mem[wr_idx] <= {entry_second_key_i, entry_first_key_i};
    end
    if (scan_re) begin
      keys_rd_q <= keys_mem[scan_addr_q[IdxW-1:0]];
    end
  end

  // code table: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (code_we) begin
      code_mem[code_waddr] <= entry_code_i;
    end
    if (code_re) begin
      code_rd_q <= code_mem[code_raddr];
    end
  end

  assign in_stall_o  = state_q != tkct_pkg::ST_IDLE;
  assign out_valid_o = out_vld_q;
  assign tap_code_o  = out_code_q;
  assign last_o      = out_last_q;

endmodule
